[hw/rtl/assert_macros.svh]
// Assertion macros shared by the conversion pipeline's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define E2Q_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define E2Q_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/e2q_pkg.sv]
// Types and constants for the angle-to-quaternion pipeline.
package e2q_pkg;

  typedef logic signed [15:0] angle_t;
  typedef logic signed [15:0] q15_t;
  typedef logic signed [33:0] cw_t;   // CORDIC word, Q2.30 with guard bits
  typedef logic signed [31:0] cs_t;   // cosine or sine, Q2.30

  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [16:0] HALF_RIGHT = 17'sd23040;   // 90 deg in Q9.8
  localparam logic signed [16:0] HALF_TURN  = 17'sd46080;   // 180 deg in Q9.8
  localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
  localparam cw_t GAIN_Q30 = 34'sd652032874;

  localparam logic signed [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
    32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
    32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
    32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
    32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
    32'sd1023,      32'sd511,       32'sd255,       32'sd127
  };

  // Half angle in radians, ready for the CORDIC.
  typedef struct packed {
    logic valid;
    logic flip;
    cw_t  z;
  } lane_t;

  // Cosine and sine of one half angle.
  typedef struct packed {
    logic valid;
    cs_t  c;
    cs_t  s;
  } trig_t;

  typedef struct packed {
    logic valid;
    q15_t w;
    q15_t x;
    q15_t y;
    q15_t z;
  } quat_t;

endpackage

[hw/rtl/e2q_if.sv]
// Valid/ready channels for angle items and quaternion items.
interface e2q_in_if;
  logic             valid;
  logic             ready;
  e2q_pkg::angle_t  yaw_angle;
  e2q_pkg::angle_t  pitch_angle;
  e2q_pkg::angle_t  roll_angle;
  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface e2q_out_if;
  logic          valid;
  logic          ready;
  e2q_pkg::q15_t quat_w;
  e2q_pkg::q15_t quat_x;
  e2q_pkg::q15_t quat_y;
  e2q_pkg::q15_t quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

[hw/rtl/e2q_prep.sv]
// Range reduction and degree-to-radian scaling of one half angle.
module e2q_prep (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  e2q_pkg::angle_t  angle,
  output e2q_pkg::lane_t   lane
);
  import e2q_pkg::*;

  logic              v1_r, f1_r, n1_r;
  logic [14:0]       mag1_r;
  logic              v2_r, f2_r, n2_r;
  logic [39:0]       prod2_r;
  lane_t             lane_r;

  logic signed [16:0] hx, hr;
  logic               flip, neg;
  logic [16:0]        habs;
  logic [40:0]        rnd;
  cw_t                zmag;

  always_comb begin
    hx   = {angle[15], angle};
    hr   = hx;
    flip = 1'b0;
    if (hx > HALF_RIGHT) begin
      hr   = hx - HALF_TURN;
      flip = 1'b1;
    end else if (hx < -HALF_RIGHT) begin
      hr   = hx + HALF_TURN;
      flip = 1'b1;
    end
    neg  = hr[16];
    habs = neg ? 17'(-hr) : 17'(hr);
  end

  always_comb begin
    rnd  = {1'b0, prod2_r} + 41'd128;
    zmag = {3'b000, rnd[38:8]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      lane_r.valid <= 1'b0;
    end else if (en) begin
      v1_r   <= in_valid;
      v2_r   <= v1_r;
      lane_r.valid <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r    <= flip;
      n1_r    <= neg;
      mag1_r  <= habs[14:0];
      f2_r    <= f1_r;
      n2_r    <= n1_r;
      prod2_r <= {25'd0, mag1_r} * {15'd0, DEG_TO_RAD_Q30};
      lane_r.flip <= f2_r;
      lane_r.z    <= n2_r ? -zmag : zmag;
    end
  end

  assign lane = lane_r;
endmodule

[hw/rtl/e2q_cordic.sv]
// Pipelined rotation-mode CORDIC, one rotation per register stage.
`include "assert_macros.svh"
module e2q_cordic #(
  parameter int STAGES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  e2q_pkg::lane_t  lane,
  output e2q_pkg::trig_t  trig
);
  import e2q_pkg::*;

  localparam int N = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;

  logic v_w [N+1];
  logic f_w [N+1];
  cw_t  x_w [N+1];
  cw_t  y_w [N+1];
  cw_t  z_w [N+1];
  trig_t trig_r;

  assign v_w[0] = lane.valid;
  assign f_w[0] = lane.flip;
  assign x_w[0] = GAIN_Q30;
  assign y_w[0] = '0;
  assign z_w[0] = lane.z;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic v_r, f_r;
    cw_t  x_r, y_r, z_r;
    cw_t  dx, dy, at;

    assign dx = x_w[i] >>> i;
    assign dy = y_w[i] >>> i;
    assign at = {{2{ATAN_Q30[i][31]}}, ATAN_Q30[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_w[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        f_r <= f_w[i];
        if (!z_w[i][33]) begin
          x_r <= x_w[i] - dy;
          y_r <= y_w[i] + dx;
          z_r <= z_w[i] - at;
        end else begin
          x_r <= x_w[i] + dy;
          y_r <= y_w[i] - dx;
          z_r <= z_w[i] + at;
        end
      end
    end

    assign v_w[i+1] = v_r;
    assign f_w[i+1] = f_r;
    assign x_w[i+1] = x_r;
    assign y_w[i+1] = y_r;
    assign z_w[i+1] = z_r;
  end

  // Undo the half-turn fold: negate both outputs when the angle was folded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r.valid <= 1'b0;
    end else if (en) begin
      trig_r.valid <= v_w[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig_r.c <= f_w[N] ? 32'(-x_w[N]) : 32'(x_w[N]);
      trig_r.s <= f_w[N] ? 32'(-y_w[N]) : 32'(y_w[N]);
    end
  end

  assign trig = trig_r;

  logic unused_z;
  assign unused_z = ^z_w[N];

  `E2Q_ASSERT_NXT(a_hold_on_stall, clk, rst_n, !en, $stable(trig_r), "CORDIC output moved while stalled")
endmodule

[hw/rtl/e2q_combine.sv]
// Product tree that forms the quaternion, with rounding and saturation.
module e2q_combine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  e2q_pkg::trig_t  yaw,
  input  e2q_pkg::trig_t  pitch,
  input  e2q_pkg::trig_t  roll,
  output e2q_pkg::quat_t  quat
);
  import e2q_pkg::*;

  typedef logic signed [32:0] pair_t;
  typedef logic signed [64:0] term_t;

  logic  va_r, vb_r;
  pair_t cc_r, ss_r, sc_r, cs_r;   // roll*pitch pairs
  cs_t   cy_r, sy_r;
  term_t t_r [8];
  quat_t quat_r;

  logic signed [63:0] p_cc, p_ss, p_sc, p_cs;

  assign p_cc = roll.c * pitch.c;
  assign p_ss = roll.s * pitch.s;
  assign p_sc = roll.s * pitch.c;
  assign p_cs = roll.c * pitch.s;

  function automatic q15_t to_q15(input term_t a, input term_t b, input logic sub);
    logic signed [65:0] sum;
    logic signed [20:0] v;
    q15_t               r;
    sum = sub ? ({a[64], a} - {b[64], b}) : ({a[64], a} + {b[64], b});
    sum = sum + (66'sd1 <<< 44);
    v   = 21'(sum >>> 45);
    if (v > 21'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -21'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      quat_r.valid <= 1'b0;
    end else if (en) begin
      va_r <= yaw.valid;
      vb_r <= va_r;
      quat_r.valid <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r <= 33'(p_cc >>> 30);
      ss_r <= 33'(p_ss >>> 30);
      sc_r <= 33'(p_sc >>> 30);
      cs_r <= 33'(p_cs >>> 30);
      cy_r <= yaw.c;
      sy_r <= yaw.s;
      t_r[0] <= cc_r * cy_r;
      t_r[1] <= ss_r * sy_r;
      t_r[2] <= sc_r * cy_r;
      t_r[3] <= cs_r * sy_r;
      t_r[4] <= cs_r * cy_r;
      t_r[5] <= sc_r * sy_r;
      t_r[6] <= cc_r * sy_r;
      t_r[7] <= ss_r * cy_r;
      quat_r.w <= to_q15(t_r[0], t_r[1], 1'b0);
      quat_r.x <= to_q15(t_r[2], t_r[3], 1'b1);
      quat_r.y <= to_q15(t_r[4], t_r[5], 1'b0);
      quat_r.z <= to_q15(t_r[6], t_r[7], 1'b1);
    end
  end

  assign quat = quat_r;
endmodule

[hw/rtl/euler_to_quaternion.sv]
// Top level: yaw/pitch/roll in degrees to a unit quaternion, fully pipelined.
//
//   channel | dir | handshake          | payload
//   in_if   | in  | valid/ready        | yaw_angle, pitch_angle, roll_angle (Q9.7 deg)
//   out_if  | out | valid/ready        | quat_w, quat_x, quat_y, quat_z (Q1.15)
//
// One item enters per cycle while out_if is not stalled. The pipe holds three prep
// stages, one per CORDIC rotation, one sign-fix stage and three product stages,
// the last being the output register.
// Reset (rst_n, synchronous) clears only the valid bits of every stage.
// A stall on out_if freezes the whole pipe in place: in_if.ready drops until
// the output register is taken, so no item is lost or repeated.
`include "assert_macros.svh"
module euler_to_quaternion #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  e2q_in_if.sink    in_if,
  e2q_out_if.source out_if
);
  import e2q_pkg::*;

  logic  pipe_en;
  lane_t yaw_lane, pitch_lane, roll_lane;
  trig_t yaw_trig, pitch_trig, roll_trig;
  quat_t quat;

  // Advance everything unless a finished item is waiting at the output.
  assign pipe_en     = !quat.valid || out_if.ready;
  assign in_if.ready = pipe_en;

  // Three independent lanes: fold, scale to radians, rotate.
  e2q_prep u_prep_yaw (
    .clk, .rst_n, .en(pipe_en), .in_valid(in_if.valid),
    .angle(in_if.yaw_angle), .lane(yaw_lane)
  );
  e2q_prep u_prep_pitch (
    .clk, .rst_n, .en(pipe_en), .in_valid(in_if.valid),
    .angle(in_if.pitch_angle), .lane(pitch_lane)
  );
  e2q_prep u_prep_roll (
    .clk, .rst_n, .en(pipe_en), .in_valid(in_if.valid),
    .angle(in_if.roll_angle), .lane(roll_lane)
  );

  e2q_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
    .clk, .rst_n, .en(pipe_en), .lane(yaw_lane), .trig(yaw_trig)
  );
  e2q_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
    .clk, .rst_n, .en(pipe_en), .lane(pitch_lane), .trig(pitch_trig)
  );
  e2q_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
    .clk, .rst_n, .en(pipe_en), .lane(roll_lane), .trig(roll_trig)
  );

  // Combine the six trig values; the yaw lane's valid bit leads the item.
  e2q_combine u_combine (
    .clk, .rst_n, .en(pipe_en),
    .yaw(yaw_trig), .pitch(pitch_trig), .roll(roll_trig), .quat
  );

  assign out_if.valid  = quat.valid;
  assign out_if.quat_w = quat.w;
  assign out_if.quat_x = quat.x;
  assign out_if.quat_y = quat.y;
  assign out_if.quat_z = quat.z;

  `E2Q_ASSERT_IMP(a_lanes_aligned, clk, rst_n, 1'b1, (yaw_trig.valid == pitch_trig.valid) && (yaw_trig.valid == roll_trig.valid), "CORDIC lanes out of step")
  `E2Q_ASSERT_NXT(a_prep_hold, clk, rst_n, !pipe_en, $stable(yaw_lane) && $stable(roll_lane), "prep stage moved while stalled")
endmodule

[test/tb_euler_to_quaternion.sv]
// Testbench for euler_to_quaternion: random and directed angle items against a bit-true predictor.
`timescale 1ns / 100ps
module tb_euler_to_quaternion;
  import e2q_pkg::*;

  localparam int STAGES    = 16;
  localparam int LATENCY   = STAGES + 7;
  localparam int IDLE_LIMIT = 20000;
  localparam longint GAIN  = 64'sd652032874;
  localparam longint D2R   = 64'sd18740330;
  localparam longint HR    = 64'sd23040;
  localparam longint HT    = 64'sd46080;

  typedef struct {
    q15_t w;
    q15_t x;
    q15_t y;
    q15_t z;
  } quat_rec_t;

  logic clk;
  logic rst_n;

  e2q_in_if  in_if ();
  e2q_out_if out_if ();

  euler_to_quaternion #(.CORDIC_STAGES(STAGES)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  // Clock: 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  quat_rec_t pending_quats[$];
  int        errors;
  int        items_sent;
  int        quats_checked;
  int        send_gap_pct;
  int        take_gap_pct;
  int        hold_off_cycles;
  int        idle_cycles;

  // Floor shift of a signed 64-bit value.
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  // Cosine and sine of half the given Q9.7 angle, Q2.30.
  function automatic void half_trig(angle_t ang, output longint c, output longint s);
    longint h;
    longint mag;
    longint z;
    longint x;
    longint y;
    longint t;
    longint dx;
    longint dy;
    bit     flip;
    h = longint'(ang);
    flip = 1'b0;
    if (h > HR) begin
      h -= HT;
      flip = 1'b1;
    end else if (h < -HR) begin
      h += HT;
      flip = 1'b1;
    end
    mag = (h < 0) ? -h : h;
    mag = (mag * D2R + 128) >>> 8;
    z = (h < 0) ? -mag : mag;
    x = GAIN;
    y = 0;
    for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        t = x - dx;
        y = y + dy;
        z -= longint'(ATAN_Q30[i]);
      end else begin
        t = x + dx;
        y = y - dy;
        z += longint'(ATAN_Q30[i]);
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint term3(longint a, longint b, longint c);
    return fshr(a * b, 30) * c;
  endfunction

  function automatic q15_t round_sat_q15(longint sum);
    longint v;
    v = fshr(sum + (64'sd1 <<< 44), 45);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return q15_t'(v);
  endfunction

  function automatic quat_rec_t zyx_quat(angle_t yaw, angle_t pitch, angle_t roll);
    longint cy, sy, cp, sp, cr, sr;
    quat_rec_t q;
    half_trig(yaw, cy, sy);
    half_trig(pitch, cp, sp);
    half_trig(roll, cr, sr);
    q.w = round_sat_q15(term3(cr, cp, cy) + term3(sr, sp, sy));
    q.x = round_sat_q15(term3(sr, cp, cy) - term3(cr, sp, sy));
    q.y = round_sat_q15(term3(cr, sp, cy) + term3(sr, cp, sy));
    q.z = round_sat_q15(term3(cr, cp, sy) - term3(sr, sp, cy));
    return q;
  endfunction

  // Append one expectation at the tail of the pending list.
  function automatic void queue_expected(quat_rec_t q);
    pending_quats = {pending_quats, q};
  endfunction

  // Offer one item, holding it until accepted; expectation is queued at acceptance.
  // Return at the falling edge after acceptance with valid still high.
  task automatic send_angles(angle_t yaw, angle_t pitch, angle_t roll);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.yaw_angle   <= yaw;
    in_if.pitch_angle <= pitch;
    in_if.roll_angle  <= roll;
    do @(posedge clk); while (!in_if.ready);
    queue_expected(zyx_quat(yaw, pitch, roll));
    items_sent++;
    @(negedge clk);
  endtask

  // Drive ready from the stall setting, or hold it low during a hold-off.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    quat_rec_t exp_q;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_quats.size() == 0) begin
        $display("%0t: unexpected quaternion w=%0d x=%0d y=%0d z=%0d", $time,
                 out_if.quat_w, out_if.quat_x, out_if.quat_y, out_if.quat_z);
        errors++;
      end else begin
        exp_q = pending_quats.pop_front();
        quats_checked++;
        if (out_if.quat_w !== exp_q.w) begin
          $display("%0t: quat_w expected %0d actual %0d", $time, exp_q.w, out_if.quat_w);
          errors++;
        end
        if (out_if.quat_x !== exp_q.x) begin
          $display("%0t: quat_x expected %0d actual %0d", $time, exp_q.x, out_if.quat_x);
          errors++;
        end
        if (out_if.quat_y !== exp_q.y) begin
          $display("%0t: quat_y expected %0d actual %0d", $time, exp_q.y, out_if.quat_y);
          errors++;
        end
        if (out_if.quat_z !== exp_q.z) begin
          $display("%0t: quat_z expected %0d actual %0d", $time, exp_q.z, out_if.quat_z);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no item accepted on either side.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Field extremes, both range-reduction edges, and saturation near zero angles.
  task automatic test_directed();
    angle_t edges[12];
    edges = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001,
              16'sd23040, 16'sd23041, -16'sd23040, -16'sd23041,
              16'sd11520, -16'sd11520, 16'sd5760};
    foreach (edges[i]) send_angles(edges[i], edges[(i + 3) % 12], edges[(i + 7) % 12]);
    send_angles(16'sh0000, 16'sh0000, 16'sh0000);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000);
    send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_angles(16'sh5555, 16'shaaaa, 16'sh5555);
    send_angles(16'shaaaa, 16'sh5555, 16'shaaaa);
    send_angles(16'sd23040, 16'sd23040, 16'sd23040);
    send_angles(-16'sd23041, -16'sd23041, -16'sd23041);
  endtask

  // Random angles, mostly full range, some near the reduction edges.
  task automatic test_random(int count);
    angle_t a[3];
    for (int n = 0; n < count; n++) begin
      foreach (a[k]) begin
        if ($urandom_range(9) == 0)
          a[k] = angle_t'(angle_t'($urandom_range(23050, 23030)) *
                          ($urandom_range(1) ? 1 : -1));
        else
          a[k] = angle_t'($urandom);
      end
      send_angles(a[0], a[1], a[2]);
    end
  endtask

  // Hold the receiver off while items keep coming so the pipe fills and stalls.
  task automatic test_backpressure();
    hold_off_cycles = 200;
    test_random(60);
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    quats_checked = 0;
    hold_off_cycles = 0;
    idle_cycles = 0;
    send_gap_pct = 0;
    take_gap_pct = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.yaw_angle = '0;
    in_if.pitch_angle = '0;
    in_if.roll_angle = '0;
    out_if.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_gap_pct = 28;
    take_gap_pct = 66;
    test_directed();
    test_random(500);
    send_gap_pct = 66;
    take_gap_pct = 28;
    test_random(500);
    send_gap_pct = 0;
    take_gap_pct = 0;
    test_backpressure();
    test_random(470);
    in_if.valid <= 1'b0;

    while (pending_quats.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);

    $display("Sent %0d angle items (edges, range-reduction bounds, random), checked %0d",
             items_sent, quats_checked);
    $display("quaternions under sender/receiver idling and a long output stall.");
    if (errors == 0 && pending_quats.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
